// ===== sv/crc16_response_deframer_macros.svh =====
// Assertion macros used by the RTL of the response deframer.
// Define NO_ASSERTIONS to compile all checks away.
`ifndef CRC16_RESPONSE_DEFRAMER_MACROS_SVH
`define CRC16_RESPONSE_DEFRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define CRD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// The consequent must hold in the cycle after the antecedent.
`define CRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`else

`define CRD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CRD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/crc16rd_pkg.sv =====
package crc16rd_pkg;

    // Reflected CRC16/ARC polynomial.
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESP_MASK     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_SEQ  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESP_CAPACITY = 8'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RST_START_BYTE = 8'hA5;
    localparam logic [7:0]  RST_RESP_MASK  = 8'h80;
    localparam logic [7:0]  RST_EXP_SEQ    = 8'h00;
    localparam logic [10:0] RST_CAPACITY   = 11'd1024;

    // Result kinds carried on tuser.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict codes.
    localparam logic [1:0] VERDICT_ACCEPTED  = 2'd0;
    localparam logic [1:0] VERDICT_BAD_CRC   = 2'd1;
    localparam logic [1:0] VERDICT_STALE_SEQ = 2'd2;
    localparam logic [1:0] VERDICT_NOT_RESP  = 2'd3;

    // Header byte positions after the start byte.
    localparam logic [2:0] HDR_TYPE    = 3'd0;
    localparam logic [2:0] HDR_SEQ     = 3'd2;
    localparam logic [2:0] HDR_LEN_LOW = 3'd3;
    localparam logic [2:0] HDR_LEN_HIGH = 3'd4;

    // Result item as carried on the output tdata; the first field sits highest.
    typedef struct packed {
        logic        pad;
        logic [10:0] copied_length;
        logic [7:0]  frame_type;
        logic [1:0]  verdict;
        logic [9:0]  payload_index;
        logic [7:0]  payload_byte;
    } t_out_item;

    localparam int OUT_DATA_W = $bits(t_out_item);

    // One byte step of the reflected CRC, LSB first.
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== sv/crc16_response_deframer.sv =====
// Receive-side deframer for a CRC16/ARC protected response link.
// Input stream: one received byte per item on s_axis_tdata[7:0].
// The block hunts for the start byte, collects a five-byte header (type, opcode,
// sequence, little-endian length), then the payload and a little-endian CRC.
// Output stream: m_axis_tuser is 0 for a tentative payload byte and 1 for the
// end-of-frame verdict; m_axis_tdata carries the result fields.
// Configuration writes use i_cfg_valid/o_cfg_ready with a register index and data,
// and are to be issued only while no frame item is in flight.
// Throughput is one item per cycle while the receiver does not stall; each item
// passes an input register and then a result register.
// The CRC byte update is a single combinational step between those registers.
// When the receiver stalls, the pending result holds in the result register and
// one more item is taken into the input register before s_axis_tready drops.
// Reset (synchronous, active low) restores the default register values, empties
// both registers and returns the block to hunting for the start byte.
`include "crc16_response_deframer_macros.svh"

module crc16_response_deframer #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: rx_byte[7:0].
    input  logic [7:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: payload_byte[7:0], payload_index[17:8], verdict[19:18],
    // frame_type[27:20], copied_length[38:28], zero fill[39].
    output logic [crc16rd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: kind[0].
    output logic        m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [crc16rd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [crc16rd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Payload counter width and a common width for capacity compares.
    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam int MW = (CW > 11) ? CW : 11;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_PL   = 2'd2;
    localparam logic [1:0] PH_CRC  = 2'd3;

    // Configuration registers.
    logic [7:0]  r_start_byte;
    logic [7:0]  r_resp_mask;
    logic [7:0]  r_exp_seq;
    logic [10:0] r_capacity;

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Frame state.
    logic [1:0]    r_phase,     n_phase;
    logic [2:0]    r_hdr_cnt,   n_hdr_cnt;
    logic [7:0]    r_type,      n_type;
    logic [7:0]    r_seq,       n_seq;
    logic [7:0]    r_len_low,   n_len_low;
    logic [CW-1:0] r_pay_len,   n_pay_len;
    logic [CW-1:0] r_pay_cnt,   n_pay_cnt;
    logic [15:0]   r_crc,       n_crc;
    logic [7:0]    r_crc_low,   n_crc_low;
    logic          r_crc_cnt,   n_crc_cnt;

    // Result register.
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_kind,  n_out_kind;
    crc16rd_pkg::t_out_item  r_out_item,  n_out_item;

    logic        w_adv;
    logic        w_fire;
    logic [15:0] w_len_full;
    logic [15:0] w_crc_step;
    logic [MW-1:0] w_cnt_ext;
    logic [MW-1:0] w_len_ext;
    logic [MW-1:0] w_cap_ext;
    logic [CW:0]   w_cnt_inc;

    // The pipeline moves whenever the result register is free or being drained.
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = r_out_item;

    assign w_len_full = {r_in_byte, r_len_low};
    assign w_crc_step = crc16rd_pkg::crc16_feed(r_crc, r_in_byte);
    assign w_cnt_ext  = MW'(r_pay_cnt);
    assign w_len_ext  = MW'(r_pay_len);
    assign w_cap_ext  = MW'(r_capacity);
    assign w_cnt_inc  = {1'b0, r_pay_cnt} + (CW+1)'(1);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= crc16rd_pkg::RST_START_BYTE;
            r_resp_mask  <= crc16rd_pkg::RST_RESP_MASK;
            r_exp_seq    <= crc16rd_pkg::RST_EXP_SEQ;
            r_capacity   <= crc16rd_pkg::RST_CAPACITY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                crc16rd_pkg::REG_START_BYTE:    r_start_byte <= i_cfg_data[7:0];
                crc16rd_pkg::REG_RESP_MASK:     r_resp_mask  <= i_cfg_data[7:0];
                crc16rd_pkg::REG_EXPECTED_SEQ:  r_exp_seq    <= i_cfg_data[7:0];
                crc16rd_pkg::REG_RESP_CAPACITY: r_capacity   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame parser: next state and result for the byte in the input register.
    always_comb begin
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_type     = r_type;
        n_seq      = r_seq;
        n_len_low  = r_len_low;
        n_pay_len  = r_pay_len;
        n_pay_cnt  = r_pay_cnt;
        n_crc      = r_crc;
        n_crc_low  = r_crc_low;
        n_crc_cnt  = r_crc_cnt;
        n_out_valid = 1'b0;
        n_out_kind  = crc16rd_pkg::KIND_PAYLOAD;
        n_out_item  = '0;

        case (r_phase)
            PH_HUNT: begin
                if (r_in_byte == r_start_byte) begin
                    n_phase   = PH_HDR;
                    n_hdr_cnt = '0;
                    n_crc     = '0;
                end
            end
            PH_HDR: begin
                n_crc = w_crc_step;
                if (r_hdr_cnt == crc16rd_pkg::HDR_TYPE) n_type = r_in_byte;
                if (r_hdr_cnt == crc16rd_pkg::HDR_SEQ) n_seq = r_in_byte;
                if (r_hdr_cnt == crc16rd_pkg::HDR_LEN_LOW) n_len_low = r_in_byte;
                if (r_hdr_cnt != crc16rd_pkg::HDR_LEN_HIGH) begin
                    n_hdr_cnt = r_hdr_cnt + 3'd1;
                end else begin
                    n_hdr_cnt = '0;
                    if (w_len_full > 16'(MAX_PAYLOAD)) begin
                        // Oversized length: drop the frame silently.
                        n_phase = PH_HUNT;
                    end else begin
                        n_pay_len = CW'(w_len_full);
                        n_pay_cnt = '0;
                        n_crc_cnt = 1'b0;
                        n_phase   = (w_len_full != 16'd0) ? PH_PL : PH_CRC;
                    end
                end
            end
            PH_PL: begin
                n_crc = w_crc_step;
                if (w_cnt_ext < w_cap_ext) begin
                    n_out_valid = 1'b1;
                    n_out_item.payload_byte  = r_in_byte;
                    n_out_item.payload_index = w_cnt_ext[9:0];
                end
                n_pay_cnt = w_cnt_inc[CW-1:0];
                if (w_cnt_inc >= {1'b0, r_pay_len}) begin
                    n_phase   = PH_CRC;
                    n_crc_cnt = 1'b0;
                end
            end
            PH_CRC: begin
                if (!r_crc_cnt) begin
                    n_crc_low = r_in_byte;
                    n_crc_cnt = 1'b1;
                end else begin
                    n_crc_cnt   = 1'b0;
                    n_phase     = PH_HUNT;
                    n_out_valid = 1'b1;
                    n_out_kind  = crc16rd_pkg::KIND_VERDICT;
                    // Verdict priority: CRC, then sequence, then response bit.
                    if ({r_in_byte, r_crc_low} != r_crc) begin
                        n_out_item.verdict = crc16rd_pkg::VERDICT_BAD_CRC;
                    end else if (r_seq != r_exp_seq) begin
                        n_out_item.verdict = crc16rd_pkg::VERDICT_STALE_SEQ;
                    end else if ((r_type & r_resp_mask) == 8'd0) begin
                        n_out_item.verdict = crc16rd_pkg::VERDICT_NOT_RESP;
                    end else begin
                        n_out_item.verdict = crc16rd_pkg::VERDICT_ACCEPTED;
                    end
                    n_out_item.frame_type    = r_type;
                    n_out_item.copied_length = (w_len_ext > w_cap_ext) ? r_capacity
                                                                       : w_len_ext[10:0];
                end
            end
            default: ;
        endcase
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Frame state advances once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_hdr_cnt <= '0;
            r_crc_cnt <= 1'b0;
        end else if (w_fire) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_crc_cnt <= n_crc_cnt;
        end
        if (w_fire) begin
            r_type    <= n_type;
            r_seq     <= n_seq;
            r_len_low <= n_len_low;
            r_pay_len <= n_pay_len;
            r_pay_cnt <= n_pay_cnt;
            r_crc     <= n_crc;
            r_crc_low <= n_crc_low;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_fire && n_out_valid;
        end
        if (w_fire) begin
            r_out_kind <= n_out_kind;
            r_out_item <= n_out_item;
        end
    end

    // Checks on the parser and the pipeline.
    `CRD_ASSERT_SAME(a_hdr_cnt_range, i_clk, i_rst_n, r_phase == PH_HDR,
        r_hdr_cnt <= crc16rd_pkg::HDR_LEN_HIGH)
    `CRD_ASSERT_SAME(a_pay_cnt_below_len, i_clk, i_rst_n, r_phase == PH_PL,
        r_pay_cnt < r_pay_len)
    `CRD_ASSERT_SAME(a_pay_len_bound, i_clk, i_rst_n, r_phase == PH_PL || r_phase == PH_CRC,
        r_pay_len <= CW'(MAX_PAYLOAD))
    `CRD_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_adv,
        r_in_valid && $stable(r_in_byte))
    `CRD_ASSERT_NEXT(a_verdict_ends_frame, i_clk, i_rst_n,
        w_fire && n_out_valid && n_out_kind == crc16rd_pkg::KIND_VERDICT,
        r_phase == PH_HUNT)

endmodule
